FILE: rtl/tsu_pkg.sv
// Trajectory spline upsampler shared definitions: field widths, register
// indexes, the spline fit mode and status codes. No dependencies.
`timescale 1ns / 1ps

package tsu_pkg;

    localparam int COORD_W = 32;
    localparam int CURV_W  = 48;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_STEPS    = 1'b1;

    localparam logic [1:0] MODE_SPLINE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FALL = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

endpackage

FILE: rtl/trajectory_spline_upsampler.sv
// Trajectory spline upsampler: per segment four setup divisions on the bit-serial divider,
// then per sample a direct step in linear mode, or three multiplications on the bit-serial
// multiplier plus one division in spline mode; m_tready stalls hold the output. One point
// is processed at a time; s_tready is high only between points.
// Reset (aresetn, synchronous, active low) clears history, sets fit_mode 1 and steps 8.
`timescale 1ns / 1ps

module trajectory_spline_upsampler #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // pos_x, pos_y, pos_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic         m_tlast,   // last_sample
    output logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tsu_pkg::*;

    localparam int NB   = $clog2(MAX_STEPS + 1);
    localparam int CW   = (NB > 7) ? NB : 7;
    localparam int NUMW = 63 + NB;
    localparam int MW   = 63;
    localparam int PW   = MW + 32;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_DIVS = 4'd2;
    localparam logic [3:0] S_DIVH = 4'd3;
    localparam logic [3:0] S_DIVX = 4'd4;
    localparam logic [3:0] S_DIVZ = 4'd5;
    localparam logic [3:0] S_SAMP = 4'd6;
    localparam logic [3:0] S_MULD = 4'd7;
    localparam logic [3:0] S_MULS = 4'd8;
    localparam logic [3:0] S_MULK = 4'd9;
    localparam logic [3:0] S_DIVQ = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [1:0]         fit_mode_reg;
    logic [6:0]         steps_reg;
    logic [3:0]         state_reg;
    logic [1:0]         ps_reg;
    coord_t             prev_x_reg, prev_y_reg, prev_z_reg;
    coord_t             cur_x_reg, cur_y_reg, cur_z_reg;
    logic [1:0]         err_st_reg;
    logic [31:0]        h_reg;
    logic signed [32:0] dx_reg, dz_reg;
    logic [NB-1:0]      n_reg;
    coord_t             s_reg, slope_reg;
    logic signed [47:0] d_reg, curv_reg;
    logic               first_reg;
    logic [31:0]        qh_reg, t_reg;
    logic [NB-1:0]      rh_reg, tr_reg;
    logic [32:0]        qx_reg, ax_reg, qz_reg, az_reg;
    logic [NB-1:0]      rx_reg, axr_reg, rz_reg, azr_reg;
    logic [NB-1:0]      j_reg;
    logic [MW-1:0]      mag_reg;
    logic signed [65:0] lin_reg;
    logic [31:0]        ox_reg, oz_reg;

    logic               div_go_reg, mul_go_reg;
    logic [NUMW-1:0]    div_num_reg;
    logic [31:0]        div_den_reg;
    logic [MW-1:0]      mul_a_reg;
    logic [31:0]        mul_b_reg;
    unit_ctl_t          div_ctl, mul_ctl;
    logic [NUMW-1:0]    div_quo;
    logic [31:0]        div_rem;
    logic [PW-1:0]      mul_prod;

    logic               m_tvalid_reg, m_tlast_reg;
    logic [95:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    tsu_div #(.NW(NUMW), .DW(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .num(div_num_reg), .den(div_den_reg), .ctl(div_ctl),
        .quo(div_quo), .rem(div_rem)
    );

    tsu_mul #(.AW(MW), .BW(32)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_go_reg),
        .a(mul_a_reg), .b(mul_b_reg), .ctl(mul_ctl), .prod(mul_prod)
    );

    coord_t             in_x, in_y, in_z;
    logic signed [32:0] dy_in, dx_in, dz_in;
    logic [32:0]        absdx_in, absdx, absdz;
    logic [CW-1:0]      steps_ext;
    logic [NB-1:0]      n_in;
    logic               out_free;
    logic               cfg_wr;
    logic               seg_in;
    logic               div_launch;
    logic               mul_launch;
    logic               emit_now;

    assign in_x     = s_tdata[31:0];
    assign in_y     = s_tdata[63:32];
    assign in_z     = s_tdata[95:64];
    assign dy_in    = {in_y[31], in_y} - {prev_y_reg[31], prev_y_reg};
    assign dx_in    = {in_x[31], in_x} - {prev_x_reg[31], prev_x_reg};
    assign dz_in    = {in_z[31], in_z} - {prev_z_reg[31], prev_z_reg};
    assign absdx_in = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
    assign absdx    = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign absdz    = dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);
    assign steps_ext = CW'(steps_reg);
    assign n_in = (steps_ext == '0) ? NB'(1) :
                  (steps_ext > CW'(MAX_STEPS)) ? NB'(MAX_STEPS) : NB'(steps_ext);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign seg_in     = s_tvalid && (ps_reg != 2'd0) && !(dy_in[32] || dy_in == '0);
    assign div_launch = ((state_reg == S_IDLE) && seg_in) ||
                        (((state_reg == S_DIVS) || (state_reg == S_DIVH) ||
                          (state_reg == S_DIVX)) && div_ctl.done) ||
                        ((state_reg == S_MULK) && mul_ctl.done);
    assign mul_launch = ((state_reg == S_SAMP) && (fit_mode_reg == MODE_SPLINE)) ||
                        (((state_reg == S_MULD) || (state_reg == S_MULS)) && mul_ctl.done);
    assign emit_now   = out_free && ((state_reg == S_ERR) || (state_reg == S_EMIT));

    // slope and curvature from the first division
    coord_t             s_calc;
    logic signed [49:0] d_sum;
    logic signed [47:0] d_calc;

    always_comb begin
        if (!dx_reg[32]) begin
            s_calc = (|div_quo[NUMW-1:31]) ? 32'sh7FFF_FFFF : coord_t'(div_quo[31:0]);
        end else begin
            s_calc = ((|div_quo[NUMW-1:32]) || (div_quo[31] && (|div_quo[30:0]))) ?
                     32'sh8000_0000 : coord_t'(-div_quo[31:0]);
        end
        d_sum = 50'(s_calc) - 50'(slope_reg) - 50'(curv_reg);
        if (first_reg) begin
            d_calc = '0;
        end else if (!d_sum[49] && (|d_sum[48:47])) begin
            d_calc = 48'sh7FFF_FFFF_FFFF;
        end else if (d_sum[49] && !(&d_sum[48:47])) begin
            d_calc = 48'sh8000_0000_0000;
        end else begin
            d_calc = d_sum[47:0];
        end
    end

    // incremental steps of floor(v*j/n)
    logic [NB:0]        t_sum, x_sum, z_sum;
    logic               t_wrap, x_wrap, z_wrap;
    logic [31:0]        t_next;
    logic [32:0]        ax_next, az_next;
    logic [NB-1:0]      tr_next, axr_next, azr_next;

    always_comb begin
        t_sum   = {1'b0, tr_reg} + {1'b0, rh_reg};
        x_sum   = {1'b0, axr_reg} + {1'b0, rx_reg};
        z_sum   = {1'b0, azr_reg} + {1'b0, rz_reg};
        t_wrap  = t_sum >= {1'b0, n_reg};
        x_wrap  = x_sum >= {1'b0, n_reg};
        z_wrap  = z_sum >= {1'b0, n_reg};
        t_next  = t_reg + qh_reg + 32'(t_wrap);
        ax_next = ax_reg + qx_reg + 33'(x_wrap);
        az_next = az_reg + qz_reg + 33'(z_wrap);
        tr_next  = t_wrap ? NB'(t_sum - {1'b0, n_reg}) : NB'(t_sum);
        axr_next = x_wrap ? NB'(x_sum - {1'b0, n_reg}) : NB'(x_sum);
        azr_next = z_wrap ? NB'(z_sum - {1'b0, n_reg}) : NB'(z_sum);
    end

    // spline sample arithmetic
    logic [PW-1:0]      prod_sh;
    logic [MW-1:0]      mag_calc;
    logic signed [65:0] lin_calc;
    logic signed [65:0] ox_sum;
    coord_t             ox_sat;
    logic [MW-1:0]      q_calc;
    logic [NB-1:0]      k_cur;

    always_comb begin
        prod_sh  = mul_prod >> FRAC_BITS;
        mag_calc = (prod_sh > (PW'(1) << 62)) ? (MW'(1) << 62) : prod_sh[MW-1:0];
        lin_calc = s_reg[31] ? -66'(prod_sh[63:0]) : 66'(prod_sh[63:0]);
        q_calc   = div_quo[MW-1:0];
        ox_sum   = 66'(prev_x_reg) + lin_reg +
                   (d_reg[47] ? 66'(q_calc) : -66'(q_calc));
        if (!ox_sum[65] && (|ox_sum[64:31])) begin
            ox_sat = 32'sh7FFF_FFFF;
        end else if (ox_sum[65] && !(&ox_sum[64:31])) begin
            ox_sat = 32'sh8000_0000;
        end else begin
            ox_sat = ox_sum[31:0];
        end
        k_cur = n_reg - j_reg;
    end

    logic [47:0] absd;
    assign absd = d_reg[47] ? 48'(-d_reg) : 48'(d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= 2'd1;
            steps_reg    <= 7'd8;
            state_reg    <= S_IDLE;
            ps_reg       <= 2'd0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
            slope_reg    <= '0;
            curv_reg     <= '0;
            div_go_reg   <= 1'b0;
            mul_go_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            div_go_reg <= div_launch;
            mul_go_reg <= mul_launch;
            if (emit_now) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == REG_FIT_MODE) begin
                    fit_mode_reg <= pwdata[1:0];
                end else begin
                    steps_reg <= pwdata[6:0];
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cur_x_reg <= in_x;
                        cur_y_reg <= in_y;
                        cur_z_reg <= in_z;
                        if (ps_reg == 2'd0) begin
                            prev_x_reg <= in_x;
                            prev_y_reg <= in_y;
                            prev_z_reg <= in_z;
                            ps_reg     <= 2'd1;
                        end else if (dy_in[32] || dy_in == '0) begin
                            err_st_reg <= dy_in[32] ? ST_FALL : ST_ZERO;
                            state_reg  <= S_ERR;
                        end else begin
                            h_reg       <= dy_in[31:0];
                            dx_reg      <= dx_in;
                            dz_reg      <= dz_in;
                            n_reg       <= n_in;
                            first_reg   <= (ps_reg == 2'd1);
                            div_num_reg <= NUMW'(absdx_in) << FRAC_BITS;
                            div_den_reg <= dy_in[31:0];
                            state_reg   <= S_DIVS;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        m_tdata_reg  <= {prev_z_reg, prev_y_reg, prev_x_reg};
                        m_tlast_reg  <= 1'b1;
                        m_tuser_reg  <= err_st_reg;
                        prev_x_reg   <= cur_x_reg;
                        prev_y_reg   <= cur_y_reg;
                        prev_z_reg   <= cur_z_reg;
                        ps_reg       <= 2'd1;
                        slope_reg    <= '0;
                        curv_reg     <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_DIVS: begin
                    if (div_ctl.done) begin
                        s_reg       <= s_calc;
                        d_reg       <= d_calc;
                        div_num_reg <= NUMW'(h_reg);
                        div_den_reg <= 32'(n_reg);
                        state_reg   <= S_DIVH;
                    end
                end
                S_DIVH: begin
                    if (div_ctl.done) begin
                        qh_reg      <= div_quo[31:0];
                        rh_reg      <= div_rem[NB-1:0];
                        div_num_reg <= NUMW'(absdx);
                        state_reg   <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (div_ctl.done) begin
                        qx_reg      <= div_quo[32:0];
                        rx_reg      <= div_rem[NB-1:0];
                        div_num_reg <= NUMW'(absdz);
                        state_reg   <= S_DIVZ;
                    end
                end
                S_DIVZ: begin
                    if (div_ctl.done) begin
                        qz_reg    <= div_quo[32:0];
                        rz_reg    <= div_rem[NB-1:0];
                        j_reg     <= '0;
                        t_reg     <= '0;
                        tr_reg    <= '0;
                        ax_reg    <= '0;
                        axr_reg   <= '0;
                        az_reg    <= '0;
                        azr_reg   <= '0;
                        state_reg <= S_SAMP;
                    end
                end
                S_SAMP: begin
                    if (fit_mode_reg == MODE_SPLINE) begin
                        mul_a_reg  <= MW'(absd);
                        mul_b_reg  <= t_reg;
                        oz_reg     <= '0;
                        state_reg  <= S_MULD;
                    end else begin
                        ox_reg    <= prev_x_reg + (dx_reg[32] ? -ax_reg[31:0] : ax_reg[31:0]);
                        oz_reg    <= prev_z_reg + (dz_reg[32] ? -az_reg[31:0] : az_reg[31:0]);
                        state_reg <= S_EMIT;
                    end
                end
                S_MULD: begin
                    if (mul_ctl.done) begin
                        mag_reg    <= mag_calc;
                        mul_a_reg  <= MW'($unsigned(s_reg[31] ? -s_reg : s_reg));
                        mul_b_reg  <= t_reg;
                        state_reg  <= S_MULS;
                    end
                end
                S_MULS: begin
                    if (mul_ctl.done) begin
                        lin_reg    <= lin_calc;
                        mul_a_reg  <= mag_reg;
                        mul_b_reg  <= 32'(k_cur);
                        state_reg  <= S_MULK;
                    end
                end
                S_MULK: begin
                    if (mul_ctl.done) begin
                        div_num_reg <= mul_prod[NUMW-1:0];
                        div_den_reg <= 32'(n_reg);
                        state_reg   <= S_DIVQ;
                    end
                end
                S_DIVQ: begin
                    if (div_ctl.done) begin
                        ox_reg    <= ox_sat;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {oz_reg, prev_y_reg + t_reg, ox_reg};
                        m_tlast_reg  <= (j_reg == n_reg - 1'b1);
                        m_tuser_reg  <= ST_OK;
                        if (j_reg == n_reg - 1'b1) begin
                            prev_x_reg <= cur_x_reg;
                            prev_y_reg <= cur_y_reg;
                            prev_z_reg <= cur_z_reg;
                            ps_reg     <= 2'd2;
                            slope_reg  <= s_reg;
                            curv_reg   <= d_reg;
                            state_reg  <= S_IDLE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            t_reg     <= t_next;
                            tr_reg    <= tr_next;
                            ax_reg    <= ax_next;
                            axr_reg   <= axr_next;
                            az_reg    <= az_next;
                            azr_reg   <= azr_next;
                            state_reg <= S_SAMP;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_STEPS) ? 32'(steps_reg) : 32'(fit_mode_reg);

endmodule

FILE: rtl/tsu_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses tsu_pkg for the unit handshake struct.
`timescale 1ns / 1ps

module tsu_div #(
    parameter int NW = 72,
    parameter int DW = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NW-1:0]         num,
    input  logic [DW-1:0]         den,
    output tsu_pkg::unit_ctl_t    ctl,
    output logic [NW-1:0]         quo,
    output logic [DW-1:0]         rem
);
    import tsu_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [DW:0]     trial;
    logic            fit;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fit   = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fit) begin
                    rem_reg <= DW'(trial - {1'b0, den_reg});
                end else begin
                    rem_reg <= trial[DW-1:0];
                end
                quo_reg <= {quo_reg[NW-2:0], fit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

FILE: rtl/tsu_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Uses tsu_pkg for the unit handshake struct.
`timescale 1ns / 1ps

module tsu_mul #(
    parameter int AW = 63,
    parameter int BW = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [AW-1:0]         a,
    input  logic [BW-1:0]         b,
    output tsu_pkg::unit_ctl_t    ctl,
    output logic [AW+BW-1:0]      prod
);
    import tsu_pkg::*;

    localparam int CNTW = $clog2(BW + 1);

    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [AW+BW-1:0] a_reg;
    logic [BW-1:0]    b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                a_reg    <= (AW+BW)'(a);
                b_reg    <= b;
                cnt_reg  <= CNTW'(BW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= {a_reg[AW+BW-2:0], 1'b0};
                b_reg   <= {1'b0, b_reg[BW-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign prod      = acc_reg;

endmodule

FILE: sim/trajectory_spline_upsampler_checker.sv
// Scoreboard for the trajectory spline upsampler: watches register writes, input and
// output beats, predicts every sample and compares it field by field. Uses tsu_pkg.
`timescale 1ns / 1ps

module trajectory_spline_upsampler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          samples_seen
);
    import tsu_pkg::*;

    localparam int                    MAX_N  = 64;
    localparam longint unsigned       CAP62  = 64'd1 << 62;
    localparam longint                CURV_HI = (64'sd1 <<< 47) - 1;
    localparam longint                CURV_LO = -(64'sd1 <<< 47);
    localparam longint                ONE_Q  = 64'sd1 <<< 16;

    typedef struct {
        coord_t     x;
        coord_t     y;
        coord_t     z;
        logic       last;
        logic [1:0] status;
    } sample_t;

    sample_t expected_samples[$];

    logic [1:0] fit_mode;
    logic [6:0] steps;
    coord_t     last_x, last_y, last_z;
    int         chain_len;
    longint     chain_slope, chain_bend;

    assign pending = expected_samples.size();

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic upsample_segment(input coord_t px, input coord_t py, input coord_t pz);
        longint          dx, dy, dz, s, d, ox, lin;
        longint unsigned h, n, j, t, a, hi, lo, r, mag, k, q;
        sample_t         smp;
        if (chain_len == 0) begin
            last_x = px; last_y = py; last_z = pz;
            chain_len = 1;
            return;
        end
        n = (steps == 0) ? 1 : steps;
        if (n > MAX_N) n = MAX_N;
        dy = longint'(py) - longint'(last_y);
        if (dy <= 0) begin
            smp.x = last_x; smp.y = last_y; smp.z = last_z;
            smp.last = 1'b1;
            smp.status = (dy == 0) ? ST_ZERO : ST_FALL;
            expected_samples.insert(expected_samples.size(), smp);
            last_x = px; last_y = py; last_z = pz;
            chain_len = 1;
            chain_slope = 0; chain_bend = 0;
            return;
        end
        h  = dy;
        dx = longint'(px) - longint'(last_x);
        dz = longint'(pz) - longint'(last_z);
        s  = sat32((dx * ONE_Q) / longint'(h));
        if (chain_len < 2) d = 0;
        else begin
            d = s - chain_slope - chain_bend;
            if (d > CURV_HI) d = CURV_HI;
            if (d < CURV_LO) d = CURV_LO;
        end
        for (j = 0; j < n; j++) begin
            t = (h * j) / n;
            smp.y = coord_t'(longint'(last_y) + longint'(t));
            if (fit_mode == MODE_SPLINE) begin
                a  = (d < 0) ? longint'(-d) : d;
                hi = (a >> 32) * t;
                lo = (a & 64'hFFFF_FFFF) * t;
                if (hi > (CAP62 >> 16)) mag = CAP62;
                else begin
                    r   = (hi << 16) + (lo >> 16);
                    mag = (r > CAP62) ? CAP62 : r;
                end
                k   = n - j;
                q   = (mag / n) * k + ((mag % n) * k) / n;
                lin = (s * longint'(t)) / ONE_Q;
                ox  = longint'(last_x) + lin;
                ox  = (d < 0) ? ox + longint'(q) : ox - longint'(q);
                smp.x = coord_t'(sat32(ox));
                smp.z = '0;
            end else begin
                smp.x = coord_t'(longint'(last_x) + (dx * longint'(j)) / longint'(n));
                smp.z = coord_t'(longint'(last_z) + (dz * longint'(j)) / longint'(n));
            end
            smp.last   = (j + 1 == n);
            smp.status = ST_OK;
            expected_samples.insert(expected_samples.size(), smp);
        end
        last_x = px; last_y = py; last_z = pz;
        chain_len   = 2;
        chain_slope = s;
        chain_bend  = d;
    endtask

    always @(posedge aclk) begin
        sample_t exp_s;
        if (!aresetn) begin
            fit_mode = 2'd1;
            steps    = 7'd8;
            last_x = '0; last_y = '0; last_z = '0;
            chain_len = 0; chain_slope = 0; chain_bend = 0;
            expected_samples.delete();
            fail_count   = 0;
            samples_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_STEPS) steps = pwdata[6:0];
                else fit_mode = pwdata[1:0];
            end
            if (m_tvalid && m_tready) begin
                samples_seen++;
                if (expected_samples.size() == 0) begin
                    $error("unexpected beat x=%h y=%h z=%h", m_tdata[31:0], m_tdata[63:32],
                           m_tdata[95:64]);
                    fail_count++;
                end else begin
                    exp_s = expected_samples.pop_front();
                    if (m_tdata[31:0] !== exp_s.x) begin
                        $error("out_x expected %h got %h", exp_s.x, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== exp_s.y) begin
                        $error("out_y expected %h got %h", exp_s.y, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== exp_s.z) begin
                        $error("out_z expected %h got %h", exp_s.z, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_s.last) begin
                        $error("last_sample expected %b got %b", exp_s.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== exp_s.status) begin
                        $error("status expected %0d got %0d", exp_s.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                upsample_segment(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
        end
    end

endmodule

FILE: sim/trajectory_spline_upsampler_tb.sv
// Testbench top for the trajectory spline upsampler: clock, reset, point stream, register
// writes and random output stalls. Depends on tsu_pkg, the upsampler and its checker.
`timescale 1ns / 1ps

module trajectory_spline_upsampler_tb;
    import tsu_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, samples_seen;
    int          points_sent;
    int          stall;
    bit          quiet;
    coord_t      walk_x, walk_y, walk_z;

    always #10 aclk = ~aclk;

    trajectory_spline_upsampler dut (.*);

    trajectory_spline_upsampler_checker chk (.*);

    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall    <= 0;
        end else if (m_tvalid && m_tready) begin
            n = quiet ? 0 : $urandom_range(0, 15);
            stall    <= n;
            m_tready <= (n == 0);
        end else if (stall > 0) begin
            stall    <= stall - 1;
            m_tready <= (stall == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
    endtask

    // hold the input until every sample is out and the block is idle again
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || !s_tready) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_point();
        int     pick;
        coord_t span;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       span = 0;
            1:       span = -coord_t'($urandom_range(1, 1 << 20));
            2, 3:    span = $urandom;
            4, 5, 6: span = $urandom_range(1, 255);
            default: span = $urandom_range(1, 100 << 16);
        endcase
        walk_y = walk_y + span;
        if ($urandom_range(0, 3) == 0) begin
            walk_x = $urandom;
            walk_z = $urandom;
        end else begin
            walk_x = walk_x + coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
            walk_z = walk_z + coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
        end
        send_point(walk_x, walk_y, walk_z);
    endtask

    initial begin
        int modes[9] = '{1, 2, 1, 0, 2, 3, 2, 1, 2};
        int nstep[9] = '{8, 1, 64, 3, 5, 127, 64, 0, 16};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        quiet     = 1'b0;
        points_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: linear, eight samples
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'h7FFF_FFFF, 32'sd1, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'sd5, 32'h7FFF_FFFF, 32'sd6);
        send_point(32'sd7, 32'h8000_0000, 32'sd8);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h1234_5678, 32'h7FFF_FFFF, 32'h1);
        drain();

        write_reg(REG_FIT_MODE, 32'(MODE_SPLINE));
        write_reg(REG_STEPS, 32'd4);
        send_point(32'sd0, 32'h8000_0000, 32'sd0);
        send_point(32'h7FFF_FFFF, 32'h8000_0001, 32'sd3);
        send_point(32'h8000_0000, 32'h8000_0002, 32'sd3);
        send_point(32'h7FFF_FFFF, 32'h8000_0003, 32'sd3);
        send_point(32'h0001_0000, 32'h8001_0003, 32'sd3);
        send_point(32'h0005_0000, 32'h8002_0003, 32'sd3);
        send_point(32'hFFF0_0000, 32'h8003_0003, 32'sd3);
        send_point(32'h7FFF_0000, 32'h7FFF_FFFF, 32'sd3);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'sd3);
        send_point(32'h0000_0100, 32'h0000_0000, 32'sd3);
        send_point(32'h0100_0000, 32'h0000_0300, 32'sd3);
        send_point(32'h8000_0000, 32'h0000_0400, 32'sd3);
        drain();

        walk_x = '0; walk_y = '0; walk_z = '0;
        for (int p = 0; p < 9; p++) begin
            quiet = (p % 3 == 2);
            write_reg(REG_FIT_MODE, modes[p]);
            write_reg(REG_STEPS, nstep[p]);
            repeat ((nstep[p] >= 64 && modes[p] == MODE_SPLINE) ? 4 : 11) random_point();
            drain();
        end

        $display("Sent %0d points over linear and spline fits with 0 to 127 steps; %0d samples",
                 points_sent, samples_seen);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #150ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/tsu_pkg.sv
rtl/tsu_div.sv
rtl/tsu_mul.sv
rtl/trajectory_spline_upsampler.sv
sim/trajectory_spline_upsampler_checker.sv
sim/trajectory_spline_upsampler_tb.sv
